### hw/rtl/eft_pkg.sv
// Shared constants, types and state encodings for the distance transform unit.
`timescale 1ns / 1ps
package eft_pkg;

	// Fixed field widths
	localparam int COST_W    = 40;
	localparam int COORD_W   = 8;
	localparam int REG_W     = 9;
	localparam int CFG_IDX_W = 1;

	// Cost of a texel that is not a seed
	localparam logic [COST_W-1:0] FAR_COST = 40'd1000000000000;

	// Register reset value and default plane limits
	localparam int REG_RESET_VAL  = 256;
	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_HEIGHT = 1'b1;

	// Item function codes
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_FETCH = 1'b1;

	// Top-level sequencer
	typedef enum logic [2:0] {
		T_IDLE,
		T_FRD,
		T_FWIN,
		T_GATHER,
		T_GWAIT,
		T_RUN
	} top_state_t;

	// Envelope engine sequencer
	typedef enum logic [3:0] {
		E_IDLE,
		E_INIT,
		E_INIT2,
		B_RD,
		B_NUM,
		B_M1,
		B_M2,
		B_CMP,
		O_RD0,
		O_CUR,
		O_CHK,
		O_NXT,
		O_CMP,
		O_SQ,
		O_OUT
	} env_state_t;

	// Engine status toward the top-level sequencer
	typedef struct packed {
		logic emit;
		logic done;
	} env_stat_t;

endpackage

### hw/rtl/eft_if.sv
// Valid/ready channel interfaces for load/fetch items and results.
`timescale 1ns / 1ps
interface eft_item_if;
	logic valid;
	logic ready;
	logic func;
	logic is_seed;

	modport source (output valid, output func, output is_seed, input ready);
	modport sink (input valid, input func, input is_seed, output ready);
endinterface

interface eft_result_if;
	logic                         valid;
	logic                         ready;
	logic [eft_pkg::COST_W-1:0]   squared_distance;
	logic [eft_pkg::COORD_W-1:0]  nearest_x;
	logic [eft_pkg::COORD_W-1:0]  nearest_y;
	logic                         last_texel;

	modport source (output valid, output squared_distance, output nearest_x,
		output nearest_y, output last_texel, input ready);
	modport sink (input valid, input squared_distance, input nearest_x,
		input nearest_y, input last_texel, output ready);
endinterface

### hw/rtl/euclidean_feature_transform_2d_unit.sv
// Top level: plane memories, load/fetch handling and the two-pass sequencer.
// Load: one texel per cycle while no result waits on the receiver. Fetch: the result is read,
// then the payload and output registers load; no item is taken until that ends. The final load
// starts a column then a row pass through one envelope engine, paced by the shared multiplier
// and the envelope pops; the unit takes no item meanwhile. Reset clears all control and pointers;
// the plane size returns to 256 by 256 (or the maximum); stored planes are undefined.
`timescale 1ns / 1ps
module euclidean_feature_transform_2d_unit #(
	parameter int MAX_WIDTH  = eft_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = eft_pkg::DEF_MAX_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	eft_item_if.sink                        items,
	eft_result_if.source                    results,
	input  logic                            cfg_we,
	input  logic [eft_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [eft_pkg::REG_W-1:0]       cfg_data
);
	localparam int MAX_SIDE = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int PLANE    = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW       = $clog2(PLANE);
	localparam int WW       = $clog2(MAX_WIDTH + 1);
	localparam int HW       = $clog2(MAX_HEIGHT + 1);
	localparam int SW       = $clog2(MAX_SIDE + 1);
	localparam int IW       = $clog2(MAX_SIDE);
	localparam int CW       = eft_pkg::COST_W;
	localparam int W_RST    = (eft_pkg::REG_RESET_VAL > MAX_WIDTH) ? MAX_WIDTH
		: eft_pkg::REG_RESET_VAL;
	localparam int H_RST    = (eft_pkg::REG_RESET_VAL > MAX_HEIGHT) ? MAX_HEIGHT
		: eft_pkg::REG_RESET_VAL;

	eft_pkg::top_state_t state_q, state_d;

	// Plane memories
	logic [CW-1:0] col_cost_mem [PLANE];
	logic [IW-1:0] win_mem      [PLANE];
	logic [CW-1:0] res_dist_mem [PLANE];
	logic [IW-1:0] res_sx_mem   [PLANE];
	logic [CW-1:0] col_rd, res_dist_rd;
	logic [IW-1:0] win_rd, res_sx_rd;

	// Sizes and pointers
	logic [WW-1:0] w_q, rw_q, lx_q, rx_q;
	logic [HW-1:0] h_q, rh_q, ly_q, ry_q;
	logic [AW-1:0] ld_addr_q, rd_addr_q, row_base_q;
	logic [WW-1:0] w_new;
	logic [HW-1:0] h_new;

	// Transform control
	logic          pass_q;
	logic [SW-1:0] outer_q, gi_q, n_len, outer_len;
	logic [AW-1:0] base_q, gaddr_q, waddr_q, stride, step;
	logic          gv_s1;
	logic [IW-1:0] gidx_s1;

	// Fetch and output registers
	logic [CW-1:0] fdist_q;
	logic [IW-1:0] fsx_q;
	logic [IW-1:0] sx_cl;
	logic [AW-1:0] win_ra;
	logic          out_valid_q, out_last_q;
	logic [CW-1:0] out_dist_q;
	logic [eft_pkg::COORD_W-1:0] out_x_q, out_y_q;

	logic in_xfer, load_xfer, fetch_xfer, load_last, rd_last;
	logic env_start;
	eft_pkg::env_stat_t env_stat;
	logic [CW-1:0] env_cost;
	logic [IW-1:0] env_arg;

	// Register clamps: zero acts as one, large values saturate
	assign w_new = (cfg_data == '0) ? WW'(1)
		: ((int'(cfg_data) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_data));
	assign h_new = (cfg_data == '0) ? HW'(1)
		: ((int'(cfg_data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_data));

	assign items.ready = (state_q == eft_pkg::T_IDLE) && (!out_valid_q || results.ready);
	assign in_xfer     = items.valid && items.ready;
	assign load_xfer   = in_xfer && (items.func == eft_pkg::FUNC_LOAD);
	assign fetch_xfer  = in_xfer && (items.func == eft_pkg::FUNC_FETCH);
	assign load_last   = (lx_q == WW'(w_q - WW'(1))) && (ly_q == HW'(h_q - HW'(1)));
	assign rd_last     = (rx_q == WW'(rw_q - WW'(1))) && (ry_q == HW'(rh_q - HW'(1)));

	// Pass geometry: column pass walks down columns, row pass along rows
	assign n_len     = pass_q ? SW'(w_q) : SW'(h_q);
	assign outer_len = pass_q ? SW'(h_q) : SW'(w_q);
	assign stride    = pass_q ? AW'(1) : AW'(w_q);
	assign step      = pass_q ? AW'(w_q) : AW'(1);

	assign sx_cl  = (SW'(res_sx_rd) >= SW'(rw_q)) ? IW'(0) : res_sx_rd;
	assign win_ra = row_base_q + AW'(sx_cl);

	assign results.valid            = out_valid_q;
	assign results.squared_distance = out_dist_q;
	assign results.nearest_x        = out_x_q;
	assign results.nearest_y        = out_y_q;
	assign results.last_texel       = out_last_q;

	// Column cost memory: loads and column-pass writes, gather reads
	always_ff @(posedge clk) begin
		if (load_xfer) begin
			col_cost_mem[ld_addr_q] <= items.is_seed ? CW'(0) : eft_pkg::FAR_COST;
		end else if (env_stat.emit && !pass_q) begin
			col_cost_mem[waddr_q] <= env_cost;
		end
		col_rd <= col_cost_mem[gaddr_q];
	end

	// Winner row and result memories
	always_ff @(posedge clk) begin
		if (env_stat.emit && !pass_q) begin
			win_mem[waddr_q] <= env_arg;
		end
		if (env_stat.emit && pass_q) begin
			res_dist_mem[waddr_q] <= env_cost;
			res_sx_mem[waddr_q]   <= env_arg;
		end
		win_rd      <= win_mem[win_ra];
		res_dist_rd <= res_dist_mem[rd_addr_q];
		res_sx_rd   <= res_sx_mem[rd_addr_q];
	end

	eft_envelope #(
		.MAX_SIDE (MAX_SIDE)
	) u_envelope (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (env_start),
		.n        (n_len),
		.line_we  (gv_s1),
		.line_wa  (gidx_s1),
		.line_wd  (col_rd),
		.stat     (env_stat),
		.out_cost (env_cost),
		.out_arg  (env_arg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= eft_pkg::T_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d   = state_q;
		env_start = 1'b0;
		unique case (state_q)
			eft_pkg::T_IDLE: begin
				if (fetch_xfer) begin
					state_d = eft_pkg::T_FRD;
				end else if (load_xfer && load_last) begin
					state_d = eft_pkg::T_GATHER;
				end
			end
			eft_pkg::T_FRD:  state_d = eft_pkg::T_FWIN;
			eft_pkg::T_FWIN: state_d = eft_pkg::T_IDLE;
			eft_pkg::T_GATHER: begin
				if (gi_q == SW'(n_len - SW'(1))) begin
					state_d = eft_pkg::T_GWAIT;
				end
			end
			eft_pkg::T_GWAIT: begin
				env_start = 1'b1;
				state_d   = eft_pkg::T_RUN;
			end
			eft_pkg::T_RUN: begin
				if (env_stat.done) begin
					if ((outer_q == SW'(outer_len - SW'(1))) && pass_q) begin
						state_d = eft_pkg::T_IDLE;
					end else begin
						state_d = eft_pkg::T_GATHER;
					end
				end
			end
			default: state_d = eft_pkg::T_IDLE;
		endcase
	end

	// Sizes, pointers and transform control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q        <= WW'(W_RST);
			h_q        <= HW'(H_RST);
			rw_q       <= WW'(W_RST);
			rh_q       <= HW'(H_RST);
			lx_q       <= '0;
			ly_q       <= '0;
			ld_addr_q  <= '0;
			rx_q       <= '0;
			ry_q       <= '0;
			rd_addr_q  <= '0;
			row_base_q <= '0;
			pass_q     <= 1'b0;
			outer_q    <= '0;
			gi_q       <= '0;
			base_q     <= '0;
			gaddr_q    <= '0;
			waddr_q    <= '0;
			gv_s1      <= 1'b0;
		end else begin
			gv_s1 <= (state_q == eft_pkg::T_GATHER);
			// Loading
			if (cfg_we) begin
				if (cfg_idx == eft_pkg::REG_PLANE_WIDTH) begin
					w_q <= w_new;
				end else begin
					h_q <= h_new;
				end
				lx_q      <= '0;
				ly_q      <= '0;
				ld_addr_q <= '0;
			end else if (load_xfer) begin
				if (load_last) begin
					lx_q      <= '0;
					ly_q      <= '0;
					ld_addr_q <= '0;
					pass_q    <= 1'b0;
					outer_q   <= '0;
					gi_q      <= '0;
					base_q    <= '0;
					gaddr_q   <= '0;
				end else begin
					ld_addr_q <= ld_addr_q + AW'(1);
					if (lx_q == WW'(w_q - WW'(1))) begin
						lx_q <= '0;
						ly_q <= ly_q + HW'(1);
					end else begin
						lx_q <= lx_q + WW'(1);
					end
				end
			end
			// Read pointer walks the last completed plane
			if (state_q == eft_pkg::T_FWIN) begin
				if (rd_last) begin
					rx_q       <= '0;
					ry_q       <= '0;
					rd_addr_q  <= '0;
					row_base_q <= '0;
				end else begin
					rd_addr_q <= rd_addr_q + AW'(1);
					if (rx_q == WW'(rw_q - WW'(1))) begin
						rx_q       <= '0;
						ry_q       <= ry_q + HW'(1);
						row_base_q <= row_base_q + AW'(rw_q);
					end else begin
						rx_q <= rx_q + WW'(1);
					end
				end
			end
			// Line gather
			if (state_q == eft_pkg::T_GATHER) begin
				gaddr_q <= gaddr_q + stride;
				gi_q    <= gi_q + SW'(1);
			end
			if (state_q == eft_pkg::T_GWAIT) begin
				waddr_q <= base_q;
			end
			// Envelope output and line stepping
			if (state_q == eft_pkg::T_RUN) begin
				if (env_stat.emit) begin
					waddr_q <= waddr_q + stride;
				end
				if (env_stat.done) begin
					gi_q <= '0;
					if (outer_q == SW'(outer_len - SW'(1))) begin
						outer_q <= '0;
						base_q  <= '0;
						gaddr_q <= '0;
						if (!pass_q) begin
							pass_q <= 1'b1;
						end else begin
							rw_q       <= w_q;
							rh_q       <= h_q;
							rx_q       <= '0;
							ry_q       <= '0;
							rd_addr_q  <= '0;
							row_base_q <= '0;
						end
					end else begin
						outer_q <= outer_q + SW'(1);
						base_q  <= base_q + step;
						gaddr_q <= base_q + step;
					end
				end
			end
		end
	end

	// Gather index pipeline and fetch payload
	always_ff @(posedge clk) begin
		gidx_s1 <= gi_q[IW-1:0];
		if (state_q == eft_pkg::T_FRD) begin
			fdist_q <= res_dist_rd;
			fsx_q   <= sx_cl;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == eft_pkg::T_FWIN) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == eft_pkg::T_FWIN) begin
			out_dist_q <= fdist_q;
			out_x_q    <= eft_pkg::COORD_W'(fsx_q);
			out_y_q    <= eft_pkg::COORD_W'(win_rd);
			out_last_q <= rd_last;
		end
	end

	// A fetch transfer shows its result once T_FRD and T_FWIN have passed
	a_fetch_latency: assert property (@(posedge clk) disable iff (!arst_n)
		fetch_xfer |-> ##3 results.valid)
		else $error("fetch result missing");

	// Engine emits line outputs only while the sequencer waits on it
	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		env_stat.emit |-> (state_q == eft_pkg::T_RUN))
		else $error("envelope output outside run");

	// A register write restarts loading at the first texel
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (ld_addr_q == '0) && (lx_q == '0) && (ly_q == '0))
		else $error("load pointer not restarted");

endmodule

### hw/rtl/eft_envelope.sv
// 1-D lower envelope of parabolas over one line, on a shared multiplier.
`timescale 1ns / 1ps
module eft_envelope #(
	parameter int MAX_SIDE = eft_pkg::DEF_MAX_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [$clog2(MAX_SIDE+1)-1:0]         n,
	input  logic                                  line_we,
	input  logic [$clog2(MAX_SIDE)-1:0]           line_wa,
	input  logic [eft_pkg::COST_W-1:0]            line_wd,
	output eft_pkg::env_stat_t                    stat,
	output logic [eft_pkg::COST_W-1:0]            out_cost,
	output logic [$clog2(MAX_SIDE)-1:0]           out_arg
);
	localparam int IW = $clog2(MAX_SIDE);
	localparam int SW = $clog2(MAX_SIDE + 1);
	localparam int CW = eft_pkg::COST_W;
	localparam int GW = CW + 1;
	localparam int NW = CW + 2;
	localparam int DW = IW + 2;
	localparam int PW = NW + DW;
	localparam int QW = 2 * IW;

	eft_pkg::env_state_t state_q, state_d;

	// Line samples and envelope stack
	logic [CW-1:0]        line_mem [MAX_SIDE];
	logic [IW-1:0]        own_mem  [MAX_SIDE];
	logic [CW-1:0]        f_mem    [MAX_SIDE];
	logic [GW-1:0]        g_mem    [MAX_SIDE];
	logic signed [NW-1:0] bn_mem   [MAX_SIDE];
	logic signed [DW-1:0] bd_mem   [MAX_SIDE];

	logic [CW-1:0]        line_rd;
	logic [IW-1:0]        st_own_rd;
	logic [CW-1:0]        st_f_rd;
	logic [GW-1:0]        st_g_rd;
	logic signed [NW-1:0] st_bn_rd;
	logic signed [DW-1:0] st_bd_rd;

	logic                 st_we;
	logic [IW-1:0]        st_wa, st_ra, st_wown;
	logic [CW-1:0]        st_wf;
	logic [GW-1:0]        st_wg;
	logic signed [NW-1:0] st_wbn;
	logic signed [DW-1:0] st_wbd;

	// Sequencer registers
	logic [IW-1:0]        k_q, top_q;
	logic [SW-1:0]        q_q;
	logic [QW-1:0]        sq_q;
	logic [CW-1:0]        fq_q;
	logic [GW-1:0]        gq_q;
	logic signed [NW-1:0] num_q, ebn_q, nxt_bn_q;
	logic signed [DW-1:0] den_q, ebd_q;
	logic signed [PW-1:0] pa_q, mul_q;
	logic [IW-1:0]        cur_own_q, nxt_own_q;
	logic [CW-1:0]        cur_f_q, nxt_f_q;

	// Shared multiplier operands
	logic signed [NW-1:0] mul_a;
	logic signed [DW-1:0] mul_b;

	logic [IW-1:0]        q_idx;
	logic [GW-1:0]        g_now;
	logic signed [NW-1:0] num_now;
	logic signed [IW:0]   dq;
	logic signed [DW-1:0] den_now;
	logic signed [IW:0]   dx;
	logic                 keep;
	logic                 adv;
	logic                 q_last;

	assign q_idx   = q_q[IW-1:0];
	assign g_now   = GW'(line_rd) + GW'(sq_q);
	assign num_now = NW'($signed({1'b0, g_now})) - NW'($signed({1'b0, st_g_rd}));
	assign dq      = $signed({1'b0, q_idx}) - $signed({1'b0, st_own_rd});
	assign den_now = {dq, 1'b0};
	assign dx      = $signed({1'b0, q_idx}) - $signed({1'b0, cur_own_q});
	// Ties pop the stack
	assign keep    = (k_q == '0) || (pa_q > mul_q);
	assign adv     = PW'(nxt_bn_q) < mul_q;
	assign q_last  = (q_q + SW'(1)) == n;

	// Memories
	always_ff @(posedge clk) begin
		if (line_we) begin
			line_mem[line_wa] <= line_wd;
		end
		line_rd <= line_mem[q_idx];
		if (st_we) begin
			own_mem[st_wa] <= st_wown;
			f_mem[st_wa]   <= st_wf;
			g_mem[st_wa]   <= st_wg;
			bn_mem[st_wa]  <= st_wbn;
			bd_mem[st_wa]  <= st_wbd;
		end
		st_own_rd <= own_mem[st_ra];
		st_f_rd   <= f_mem[st_ra];
		st_g_rd   <= g_mem[st_ra];
		st_bn_rd  <= bn_mem[st_ra];
		st_bd_rd  <= bd_mem[st_ra];
	end

	// Multiplier, registered
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= eft_pkg::E_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, memory and multiplier control
	always_comb begin
		state_d  = state_q;
		st_we    = 1'b0;
		st_wa    = k_q + IW'(1);
		st_wown  = q_idx;
		st_wf    = fq_q;
		st_wg    = gq_q;
		st_wbn   = num_q;
		st_wbd   = den_q;
		st_ra    = k_q;
		mul_a    = num_q;
		mul_b    = ebd_q;
		stat     = '0;
		out_cost = mul_q[CW-1:0] + cur_f_q;
		out_arg  = cur_own_q;
		unique case (state_q)
			eft_pkg::E_IDLE: begin
				if (start) begin
					state_d = eft_pkg::E_INIT;
				end
			end
			eft_pkg::E_INIT: state_d = eft_pkg::E_INIT2;
			eft_pkg::E_INIT2: begin
				st_we   = 1'b1;
				st_wa   = '0;
				st_wown = '0;
				st_wf   = line_rd;
				st_wg   = GW'(line_rd);
				st_wbn  = '0;
				st_wbd  = '0;
				state_d = (n == SW'(1)) ? eft_pkg::O_RD0 : eft_pkg::B_RD;
			end
			eft_pkg::B_RD:  state_d = eft_pkg::B_NUM;
			eft_pkg::B_NUM: state_d = eft_pkg::B_M1;
			eft_pkg::B_M1:  state_d = eft_pkg::B_M2;
			eft_pkg::B_M2: begin
				mul_a   = ebn_q;
				mul_b   = den_q;
				state_d = eft_pkg::B_CMP;
			end
			eft_pkg::B_CMP: begin
				if (keep) begin
					st_we   = 1'b1;
					state_d = q_last ? eft_pkg::O_RD0 : eft_pkg::B_RD;
				end else begin
					state_d = eft_pkg::B_RD;
				end
			end
			eft_pkg::O_RD0: state_d = eft_pkg::O_CUR;
			eft_pkg::O_CUR: state_d = eft_pkg::O_CHK;
			eft_pkg::O_CHK: begin
				st_ra   = k_q + IW'(1);
				state_d = (k_q < top_q) ? eft_pkg::O_NXT : eft_pkg::O_SQ;
			end
			eft_pkg::O_NXT: begin
				mul_a   = NW'($signed({1'b0, q_idx}));
				mul_b   = st_bd_rd;
				state_d = eft_pkg::O_CMP;
			end
			eft_pkg::O_CMP: state_d = adv ? eft_pkg::O_CHK : eft_pkg::O_SQ;
			eft_pkg::O_SQ: begin
				mul_a   = NW'(dx);
				mul_b   = DW'(dx);
				state_d = eft_pkg::O_OUT;
			end
			eft_pkg::O_OUT: begin
				stat.emit = 1'b1;
				stat.done = q_last;
				state_d   = q_last ? eft_pkg::E_IDLE : eft_pkg::O_CHK;
			end
			default: state_d = eft_pkg::E_IDLE;
		endcase
	end

	// Datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q   <= '0;
			top_q <= '0;
			q_q   <= '0;
			sq_q  <= '0;
		end else begin
			case (state_q)
				eft_pkg::E_IDLE: begin
					q_q <= '0;
					k_q <= '0;
				end
				eft_pkg::E_INIT2: begin
					k_q   <= '0;
					top_q <= '0;
					q_q   <= (n == SW'(1)) ? SW'(0) : SW'(1);
					sq_q  <= QW'(1);
				end
				eft_pkg::B_CMP: begin
					if (keep) begin
						if (q_last) begin
							top_q <= k_q + IW'(1);
							k_q   <= '0;
							q_q   <= '0;
						end else begin
							k_q  <= k_q + IW'(1);
							q_q  <= q_q + SW'(1);
							sq_q <= sq_q + QW'({q_q, 1'b1});
						end
					end else begin
						k_q <= k_q - IW'(1);
					end
				end
				eft_pkg::O_CMP: begin
					if (adv) begin
						k_q <= k_q + IW'(1);
					end
				end
				eft_pkg::O_OUT: q_q <= q_q + SW'(1);
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			eft_pkg::B_NUM: begin
				fq_q  <= line_rd;
				gq_q  <= g_now;
				num_q <= num_now;
				den_q <= den_now;
				ebn_q <= st_bn_rd;
				ebd_q <= st_bd_rd;
			end
			eft_pkg::B_M2: pa_q <= mul_q;
			eft_pkg::O_CUR: begin
				cur_own_q <= st_own_rd;
				cur_f_q   <= st_f_rd;
			end
			eft_pkg::O_NXT: begin
				nxt_own_q <= st_own_rd;
				nxt_f_q   <= st_f_rd;
				nxt_bn_q  <= st_bn_rd;
			end
			eft_pkg::O_CMP: begin
				if (adv) begin
					cur_own_q <= nxt_own_q;
					cur_f_q   <= nxt_f_q;
				end
			end
			default: ;
		endcase
	end

endmodule

### bench/euclidean_feature_transform_2d_unit_tb.sv
// Self-checking testbench for the 2-D distance and feature transform unit.
`timescale 1ns / 1ps
module euclidean_feature_transform_2d_unit_tb;

	localparam int PLANE_MAX = eft_pkg::DEF_MAX_WIDTH * eft_pkg::DEF_MAX_HEIGHT;
	localparam int SIDE_MAX  = eft_pkg::DEF_MAX_WIDTH;
	localparam int STALL_LIMIT = 100000;

	typedef struct {
		logic [eft_pkg::COST_W-1:0]  sq_dist;
		logic [eft_pkg::COORD_W-1:0] x;
		logic [eft_pkg::COORD_W-1:0] y;
		logic                        last;
	} texel_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [eft_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [eft_pkg::REG_W-1:0] cfg_data;

	eft_item_if   item_ch ();
	eft_result_if result_ch ();

	euclidean_feature_transform_2d_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.items(item_ch),
		.results(result_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	// Predictor state: column pass data, results, pointers and sizes
	logic [eft_pkg::COST_W-1:0]  col_cost [PLANE_MAX];
	logic [eft_pkg::COORD_W-1:0] col_row  [PLANE_MAX];
	logic [eft_pkg::COST_W-1:0]  res_dist [PLANE_MAX];
	logic [eft_pkg::COORD_W-1:0] res_sx   [PLANE_MAX];
	longint line_in  [SIDE_MAX];
	longint line_out [SIDE_MAX];
	int     line_arg [SIDE_MAX];
	int     owner    [SIDE_MAX];
	longint bnum     [SIDE_MAX+1];
	longint bden     [SIDE_MAX+1];
	int load_pos, read_pos, cur_w, cur_h, done_w, done_h;

	texel_result_t pending_texels[$];
	int errors;
	int send_idle_pct, recv_stall_pct;
	int idle_cycles;

	// Clock
	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// 1-D lower envelope of parabolas over line_in[0..n-1]
	function automatic void envelope_1d(int n);
		int k, top, q, p;
		longint num, den, dx;
		k = 0;
		owner[0] = 0;
		for (q = 1; q < n; q++) begin
			while (1) begin
				p = owner[k];
				num = (line_in[q] + longint'(q) * q) - (line_in[p] + longint'(p) * p);
				den = 2 * (longint'(q) - p);
				if (k == 0 || num * bden[k] > bnum[k] * den)
					break;
				k--;
			end
			k++;
			owner[k] = q;
			bnum[k] = num;
			bden[k] = den;
		end
		top = k;
		k = 0;
		for (q = 0; q < n; q++) begin
			while (k < top && bnum[k+1] < longint'(q) * bden[k+1])
				k++;
			p = owner[k];
			dx = longint'(q) - p;
			line_out[q] = dx * dx + line_in[p];
			line_arg[q] = p;
		end
	endfunction

	// Column pass then row pass over the loaded plane
	function automatic void transform_plane(int w, int h);
		for (int x = 0; x < w; x++) begin
			for (int y = 0; y < h; y++)
				line_in[y] = longint'(col_cost[y*w+x]);
			envelope_1d(h);
			for (int y = 0; y < h; y++) begin
				col_cost[y*w+x] = line_out[y][eft_pkg::COST_W-1:0];
				col_row[y*w+x] = line_arg[y][eft_pkg::COORD_W-1:0];
			end
		end
		for (int y = 0; y < h; y++) begin
			for (int x = 0; x < w; x++)
				line_in[x] = longint'(col_cost[y*w+x]);
			envelope_1d(w);
			for (int x = 0; x < w; x++) begin
				res_dist[y*w+x] = line_out[x][eft_pkg::COST_W-1:0];
				res_sx[y*w+x] = line_arg[x][eft_pkg::COORD_W-1:0];
			end
		end
	endfunction

	function automatic int clamp_side(logic [eft_pkg::REG_W-1:0] v, int lim);
		if (v == 0)
			return 1;
		if (v > lim)
			return lim;
		return int'(v);
	endfunction

	// Update the predictor for one accepted item
	function automatic void predict_item(logic f, logic seed);
		int total, idx, y, sx;
		texel_result_t r;
		if (f == eft_pkg::FUNC_LOAD) begin
			total = cur_w * cur_h;
			if (load_pos >= total)
				load_pos = 0;
			col_cost[load_pos] = seed ? '0 : eft_pkg::FAR_COST;
			load_pos++;
			if (load_pos == total) begin
				transform_plane(cur_w, cur_h);
				done_w = cur_w;
				done_h = cur_h;
				load_pos = 0;
				read_pos = 0;
			end
		end else begin
			total = done_w * done_h;
			if (read_pos >= total)
				read_pos = 0;
			idx = read_pos;
			y = idx / done_w;
			sx = int'(res_sx[idx]);
			if (sx >= done_w)
				sx = 0;
			r.sq_dist = res_dist[idx];
			r.x = sx[eft_pkg::COORD_W-1:0];
			r.y = col_row[y*done_w+sx];
			r.last = (idx + 1 == total);
			pending_texels = {pending_texels, r};
			read_pos = r.last ? 0 : idx + 1;
		end
	endfunction

	// Send one item; valid stays high after the transfer until the next call or a drain
	task automatic send_item(logic f, logic seed);
		if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct)
				@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.func <= f;
		item_ch.is_seed <= seed;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		predict_item(f, seed);
	endtask

	task automatic load_texel(logic seed);
		send_item(eft_pkg::FUNC_LOAD, seed);
	endtask

	task automatic fetch_texel();
		send_item(eft_pkg::FUNC_FETCH, 1'($urandom_range(0, 1)));
	endtask

	// Wait for every expected result, then let a running transform finish
	task automatic drain_results();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_texels.size() != 0)
			@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [eft_pkg::CFG_IDX_W-1:0] idx,
		logic [eft_pkg::REG_W-1:0] data);
		drain_results();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == eft_pkg::REG_PLANE_WIDTH)
			cur_w = clamp_side(data, eft_pkg::DEF_MAX_WIDTH);
		else
			cur_h = clamp_side(data, eft_pkg::DEF_MAX_HEIGHT);
		load_pos = 0;
	endtask

	task automatic set_plane(logic [eft_pkg::REG_W-1:0] w, logic [eft_pkg::REG_W-1:0] h);
		write_reg(eft_pkg::REG_PLANE_WIDTH, w);
		write_reg(eft_pkg::REG_PLANE_HEIGHT, h);
	endtask

	// Load a whole plane; seeds appear with the given percentage
	task automatic load_plane(int seed_pct);
		for (int i = 0; i < cur_w * cur_h; i++)
			load_texel($urandom_range(0, 99) < seed_pct);
	endtask

	// Tiny planes: 1x1 with and without seed, read-pointer wrap
	task automatic test_single_texel();
		set_plane(9'd0, 9'd1);
		load_texel(1'b1);
		fetch_texel();
		fetch_texel();
		load_texel(1'b0);
		fetch_texel();
	endtask

	// Plane without seeds reports FAR plus self as nearest
	task automatic test_no_seed();
		set_plane(9'd3, 9'd2);
		load_plane(0);
		repeat (7) fetch_texel();
	endtask

	// Loading a new plane leaves old results readable until it completes
	task automatic test_load_during_read();
		set_plane(9'd3, 9'd3);
		load_texel(1'b1);
		repeat (7) load_texel(1'b0);
		load_texel(1'b1);
		repeat (2) fetch_texel();
		repeat (4) load_texel(1'b0);
		repeat (8) fetch_texel();
		load_texel(1'b0);
		load_texel(1'b1);
		repeat (3) load_texel(1'b0);
		repeat (3) fetch_texel();
	endtask

	// A register write abandons a partly loaded plane
	task automatic test_abandon_partial();
		set_plane(9'd2, 9'd2);
		load_plane(50);
		repeat (3) load_texel(1'b1);
		write_reg(eft_pkg::REG_PLANE_HEIGHT, 9'd2);
		load_texel(1'b0);
		load_texel(1'b0);
		load_texel(1'b0);
		load_texel(1'b1);
		repeat (5) fetch_texel();
	endtask

	// Register extremes: width saturates to 256, zero height acts as one
	task automatic test_extreme_sizes();
		set_plane(9'd511, 9'd0);
		load_plane(3);
		repeat (6) fetch_texel();
	endtask

	// Random planes, fetches interleaved with loads of the next plane
	task automatic test_random_planes(int n_items, int s_idle, int r_stall, bit hold_off);
		int sent, w, h, total, density, n_fetch;
		send_idle_pct = s_idle;
		recv_stall_pct = r_stall;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				w = $urandom_range(1, 8);
				h = $urandom_range(1, 8);
			end else begin
				w = $urandom_range(1, 6);
				h = $urandom_range(1, 6);
			end
			set_plane(w[eft_pkg::REG_W-1:0], h[eft_pkg::REG_W-1:0]);
			total = cur_w * cur_h;
			case ($urandom_range(0, 3))
				0: density = 0;
				1: density = 5;
				2: density = 30;
				default: density = 80;
			endcase
			load_plane(density);
			sent += total;
			n_fetch = $urandom_range(1, total + 2);
			for (int i = 0; i < n_fetch; i++) begin
				if ($urandom_range(0, 9) < 2) begin
					load_texel($urandom_range(0, 99) < density);
					sent++;
				end
				fetch_texel();
				sent++;
			end
			if (hold_off) begin
				item_ch.valid <= 1'b0;
				@(posedge clk);
				while (pending_texels.size() != 0)
					@(posedge clk);
				hold_off = 0;
			end
		end
	endtask

	// Result checking and receiver stalls
	always @(posedge clk) begin
		texel_result_t e;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_texels.size() == 0) begin
				$error("unexpected result transfer");
				errors++;
			end else begin
				e = pending_texels.pop_front();
				if (result_ch.squared_distance !== e.sq_dist) begin
					$error("squared_distance expected %0d got %0d", e.sq_dist,
						result_ch.squared_distance);
					errors++;
				end
				if (result_ch.nearest_x !== e.x) begin
					$error("nearest_x expected %0d got %0d", e.x, result_ch.nearest_x);
					errors++;
				end
				if (result_ch.nearest_y !== e.y) begin
					$error("nearest_y expected %0d got %0d", e.y, result_ch.nearest_y);
					errors++;
				end
				if (result_ch.last_texel !== e.last) begin
					$error("last_texel expected %0d got %0d", e.last,
						result_ch.last_texel);
					errors++;
				end
			end
		end
		result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("euclidean_feature_transform_2d_unit_tb failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.func = eft_pkg::FUNC_LOAD;
		item_ch.is_seed = 1'b0;
		result_ch.ready = 1'b0;
		errors = 0;
		idle_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cur_w = eft_pkg::DEF_MAX_WIDTH;
		cur_h = eft_pkg::DEF_MAX_HEIGHT;
		done_w = eft_pkg::DEF_MAX_WIDTH;
		done_h = eft_pkg::DEF_MAX_HEIGHT;
		load_pos = 0;
		read_pos = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_texel();
		test_no_seed();
		test_load_during_read();
		test_abandon_partial();
		test_extreme_sizes();
		test_random_planes(30, 9, 75, 1'b1);
		test_random_planes(30, 75, 9, 1'b0);
		test_random_planes(30, 0, 0, 1'b0);

		// Final drain
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_texels.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("euclidean_feature_transform_2d_unit_tb passed");
		else
			$display("euclidean_feature_transform_2d_unit_tb failed");
		$finish;
	end

endmodule
